/* design/bce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_pkg
// Shared constants, types and helpers for the Bernstein curve evaluator.
// ----------------------------------------------------------------------------
package bce_pkg;

    // Sizing of the evaluator.
    localparam int MAX_COEFFS     = 6;
    localparam int MIN_COEFFS     = 2;
    localparam int POSITION_WIDTH = 16;

    // Field widths fixed by the register map and the result format.
    localparam int NUM_COEF_REGS  = 6;
    localparam int COEF_W         = 16;
    localparam int SHAPE_W        = 16;
    localparam int NCOEF_W        = 3;
    localparam int RECIP_W        = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    // Q0.16 fraction with room for the value 1.0.
    localparam int FRAC_W         = 16;
    localparam int Q_W            = FRAC_W + 1;

    localparam int IDX_W          = $clog2(MAX_COEFFS);
    localparam int COEF_IDX_W     = $clog2(NUM_COEF_REGS);
    localparam int BINOM_W        = MAX_COEFFS - 1;
    localparam int WGT_W          = COEF_W + BINOM_W + 1;
    localparam int ACC_W          = COEF_W + Q_W + MAX_COEFFS;
    localparam int SCALED_W       = POSITION_WIDTH + RECIP_W;

    localparam logic [Q_W-1:0] ONE_Q16  = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [Q_W-1:0] HALF_Q16 = {2'b01, {(FRAC_W - 1){1'b0}}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEFFS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_RECIP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ZERO  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_THREE = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FOUR  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIVE  = CFG_IDX_W'(7);

    localparam logic [NCOEF_W-1:0] NUM_COEFFS_RST = NCOEF_W'(6);
    localparam logic [RECIP_W-1:0] SPAN_RECIP_RST = RECIP_W'(65536);

    typedef logic [Q_W-1:0] t_q16;

    // Data handed along the chain of power cells.
    typedef struct packed {
        t_q16                  t;
        t_q16                  u;
        t_q16 [MAX_COEFFS-1:0] tp;
        t_q16 [MAX_COEFFS-1:0] up;
    } t_pow_data;

    // Data handed along the chain of multiply-accumulate cells.
    typedef struct packed {
        logic [ACC_W-1:0]                  acc;
        logic [MAX_COEFFS-1:0][WGT_W-1:0]  wgt;
        t_q16 [MAX_COEFFS-1:0]             prod;
    } t_term_data;

    // Product of two Q0.16 values, rounded half up.
    function automatic t_q16 mul_q16(input t_q16 a, input t_q16 b);
        logic [2*Q_W-1:0] prod;
        prod = a * b;
        prod = prod + (2*Q_W)'(HALF_Q16);
        return prod[FRAC_W +: Q_W];
    endfunction

    // Binomial coefficient through Pascal's triangle; used for constants only.
    function automatic int binom(input int d, input int k);
        int row [MAX_COEFFS];
        int r;
        int j;
        for (j = 0; j < MAX_COEFFS; j++) begin
            row[j] = 0;
        end
        row[0] = 1;
        for (r = 1; r <= d; r++) begin
            for (j = r; j >= 1; j--) begin
                row[j] = row[j] + row[j-1];
            end
        end
        return row[k];
    endfunction

endpackage

/* design/bce_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_in_if
// Sample position channel with valid/ready flow control.
// ----------------------------------------------------------------------------
interface bce_in_if;
    logic                                valid;
    logic                                ready;
    logic [bce_pkg::POSITION_WIDTH-1:0]  sample_position;

    modport source (output valid, output sample_position, input ready);
    modport sink   (input valid, input sample_position, output ready);
endinterface

/* design/bce_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_out_if
// Shape value channel with valid/ready flow control.
// ----------------------------------------------------------------------------
interface bce_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [bce_pkg::SHAPE_W-1:0] shape_value;

    modport source (output valid, output shape_value, input ready);
    modport sink   (input valid, input shape_value, output ready);
endinterface

/* design/bce_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_norm
// Scales the position by the span reciprocal and clips t to 1.0.
// ----------------------------------------------------------------------------
module bce_norm (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [bce_pkg::POSITION_WIDTH-1:0]    i_pos,
    input  logic [bce_pkg::RECIP_W-1:0]           i_recip,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output bce_pkg::t_pow_data                    o_data
);

    localparam int TR_W   = bce_pkg::SCALED_W - bce_pkg::FRAC_W;
    localparam int CLIP_W = (TR_W > bce_pkg::Q_W) ? TR_W : bce_pkg::Q_W;

    logic                              r_va;
    logic [bce_pkg::SCALED_W-1:0]      r_scaled;
    logic                              r_vb;
    bce_pkg::t_pow_data                r_data;
    bce_pkg::t_pow_data                n_data;
    logic                              w_rdy_a;
    logic                              w_rdy_b;
    logic [CLIP_W-1:0]                 w_traw;
    bce_pkg::t_q16                     w_t;

    assign w_rdy_b = !r_vb || i_ready;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_scaled <= bce_pkg::SCALED_W'(i_pos) * bce_pkg::SCALED_W'(i_recip);
        end
        if (w_rdy_b && r_va) begin
            r_data <= n_data;
        end
    end

    assign w_traw = CLIP_W'(r_scaled >> bce_pkg::FRAC_W);
    assign w_t    = (w_traw > CLIP_W'(bce_pkg::ONE_Q16)) ? bce_pkg::ONE_Q16
                                                         : bce_pkg::Q_W'(w_traw);

    // Zeroth powers are 1.0; the power cells fill in the rest.
    always_comb begin
        n_data       = '0;
        n_data.t     = w_t;
        n_data.u     = bce_pkg::ONE_Q16 - w_t;
        n_data.tp[0] = bce_pkg::ONE_Q16;
        n_data.up[0] = bce_pkg::ONE_Q16;
    end

    assign o_valid = r_vb;
    assign o_data  = r_data;

endmodule

/* design/bce_power_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_power_cell
// One link of the power chain: forms t^k and (1-t)^k from the previous powers.
// ----------------------------------------------------------------------------
module bce_power_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bce_pkg::IDX_W-1:0]   i_idx,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bce_pkg::t_pow_data          i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output bce_pkg::t_pow_data          o_data
);

    logic                        r_valid;
    bce_pkg::t_pow_data          r_data;
    bce_pkg::t_pow_data          n_data;
    logic [bce_pkg::IDX_W-1:0]   w_prev;

    assign o_ready = !r_valid || i_ready;
    assign w_prev  = bce_pkg::IDX_W'(i_idx - 1'b1);

    always_comb begin
        n_data            = i_data;
        n_data.tp[i_idx]  = bce_pkg::mul_q16(i_data.tp[w_prev], i_data.t);
        n_data.up[i_idx]  = bce_pkg::mul_q16(i_data.up[w_prev], i_data.u);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* design/bce_basis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_basis
// Forms the power products of every basis term and the binomial-scaled weights.
// ----------------------------------------------------------------------------
module bce_basis (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic [bce_pkg::IDX_W-1:0]                             i_deg,
    input  logic [bce_pkg::NUM_COEF_REGS-1:0][bce_pkg::COEF_W-1:0] i_coef,
    input  logic                                                  i_valid,
    output logic                                                  o_ready,
    input  bce_pkg::t_pow_data                                    i_data,
    output logic                                                  o_valid,
    input  logic                                                  i_ready,
    output bce_pkg::t_term_data                                   o_data
);

    logic [bce_pkg::BINOM_W-1:0]     w_binom [bce_pkg::MAX_COEFFS][bce_pkg::MAX_COEFFS];
    bce_pkg::t_q16                   w_prod  [bce_pkg::MAX_COEFFS];
    logic signed [bce_pkg::WGT_W-1:0] w_wgt  [bce_pkg::MAX_COEFFS];
    logic                            r_valid;
    bce_pkg::t_term_data             r_data;
    bce_pkg::t_term_data             n_data;

    assign o_ready = !r_valid || i_ready;

    // Binomial coefficients, one constant per degree and term.
    for (genvar gd = 0; gd < bce_pkg::MAX_COEFFS; gd++) begin : g_deg
        for (genvar gk = 0; gk < bce_pkg::MAX_COEFFS; gk++) begin : g_term
            assign w_binom[gd][gk] = bce_pkg::BINOM_W'(bce_pkg::binom(gd, gk));
        end
    end

    // Terms above the degree get a zero weight and drop out of the sum.
    // The signed product is sized on its own so that the zero arm of the
    // select cannot turn it unsigned.
    for (genvar gi = 0; gi < bce_pkg::MAX_COEFFS; gi++) begin : g_lane
        logic                        w_use;
        logic [bce_pkg::IDX_W-1:0]   w_uidx;

        assign w_use  = (bce_pkg::IDX_W'(gi) <= i_deg);
        assign w_uidx = w_use ? bce_pkg::IDX_W'(i_deg - bce_pkg::IDX_W'(gi)) : '0;
        assign w_prod[gi] = bce_pkg::mul_q16(i_data.tp[gi], i_data.up[w_uidx]);
        assign w_wgt[gi]  = w_use ? bce_pkg::WGT_W'($signed(i_coef[gi])
                                        * $signed({1'b0, w_binom[i_deg][gi]}))
                                  : '0;
    end

    always_comb begin
        n_data     = '0;
        for (int i = 0; i < bce_pkg::MAX_COEFFS; i++) begin
            n_data.prod[i] = w_prod[i];
            n_data.wgt[i]  = w_wgt[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* design/bce_term_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_term_cell
// One link of the accumulation chain: adds weight times product of its term.
// ----------------------------------------------------------------------------
module bce_term_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bce_pkg::IDX_W-1:0]   i_idx,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bce_pkg::t_term_data         i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output bce_pkg::t_term_data         o_data
);

    logic                              r_valid;
    bce_pkg::t_term_data               r_data;
    bce_pkg::t_term_data               n_data;
    logic signed [bce_pkg::ACC_W-1:0]  w_term;

    assign o_ready = !r_valid || i_ready;

    // Signed weight times unsigned Q0.16 product, exact in Q4.28.
    assign w_term = $signed(i_data.wgt[i_idx]) * $signed({1'b0, i_data.prod[i_idx]});

    always_comb begin
        n_data     = i_data;
        n_data.acc = i_data.acc + w_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* design/bernstein_curve_eval_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bernstein_curve_eval_core
// Pipelined Bernstein polynomial evaluator, one sample position per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Sample positions arrive on i_in and one shape value leaves on o_out for
//   each of them, in order. Both channels complete a transfer on a rising
//   edge where valid and ready are high. The position is scaled by the span
//   reciprocal into t (Q0.16, clipped at 1.0); the result is the sum of the
//   enabled coefficients weighted by their Bernstein basis terms, rounded to
//   Q4.12 and saturated.
//   Throughput is one item per clock while the receiver keeps up. A result
//   is registered through the two normalizing stages, the chain of power
//   cells (one cell per power), the basis stage, the chain of
//   multiply-accumulate cells (one per coefficient) and the output register.
//   Every stage has its own valid bit and takes new data whenever it is empty
//   or its successor moves, so bubbles close up and new positions are taken
//   while a finished result waits in the output register. When the receiver
//   stalls long enough the chain fills and i_in.ready drops.
//   Reset clears all stages and loads the register defaults (six
//   coefficients, reciprocal 1.0, all weights zero). Registers are written
//   through i_cfg_* and must only change while no item is in flight.
// ----------------------------------------------------------------------------
module bernstein_curve_eval_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bce_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bce_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    bce_in_if.sink                              i_in,
    bce_out_if.source                           o_out
);

    localparam int NP    = bce_pkg::MAX_COEFFS;
    localparam int RES_W = bce_pkg::ACC_W - bce_pkg::FRAC_W;
    localparam logic signed [RES_W-1:0] RES_MAX =
        {{(RES_W - bce_pkg::SHAPE_W + 1){1'b0}}, {(bce_pkg::SHAPE_W - 1){1'b1}}};
    localparam logic signed [RES_W-1:0] RES_MIN =
        {{(RES_W - bce_pkg::SHAPE_W + 1){1'b1}}, {(bce_pkg::SHAPE_W - 1){1'b0}}};

    // Configuration registers.
    logic [bce_pkg::NCOEF_W-1:0]                          r_num_coeffs;
    logic [bce_pkg::RECIP_W-1:0]                          r_span_recip;
    logic [bce_pkg::NUM_COEF_REGS-1:0][bce_pkg::COEF_W-1:0] r_coef;

    // Chain links: index 0 is the head of each chain.
    logic                    w_pv [NP];
    logic                    w_pr [NP];
    bce_pkg::t_pow_data      w_pd [NP];
    logic                    w_tv [NP+1];
    logic                    w_tr [NP+1];
    bce_pkg::t_term_data     w_td [NP+1];

    logic [bce_pkg::NCOEF_W-1:0]      w_ncoef;
    logic [bce_pkg::IDX_W-1:0]        w_deg;
    logic                             w_out_rdy;
    logic signed [bce_pkg::ACC_W-1:0] w_acc_rnd;
    logic signed [RES_W-1:0]          w_res;
    logic signed [bce_pkg::SHAPE_W-1:0] w_shape;
    logic                             w_chain_busy;

    logic                             r_out_valid;
    logic signed [bce_pkg::SHAPE_W-1:0] r_shape;

    // ------------------------------------------------------------------
    // Register writes. Indexes past the list of registers do nothing.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_coeffs <= bce_pkg::NUM_COEFFS_RST;
            r_span_recip <= bce_pkg::SPAN_RECIP_RST;
            r_coef       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                bce_pkg::CFG_NUM_COEFFS: begin
                    r_num_coeffs <= i_cfg_data[bce_pkg::NCOEF_W-1:0];
                end
                bce_pkg::CFG_SPAN_RECIP: begin
                    r_span_recip <= i_cfg_data[bce_pkg::RECIP_W-1:0];
                end
                bce_pkg::CFG_COEF_ZERO, bce_pkg::CFG_COEF_ONE, bce_pkg::CFG_COEF_TWO,
                bce_pkg::CFG_COEF_THREE, bce_pkg::CFG_COEF_FOUR,
                bce_pkg::CFG_COEF_FIVE: begin
                    r_coef[bce_pkg::COEF_IDX_W'(i_cfg_idx - bce_pkg::CFG_COEF_ZERO)]
                        <= i_cfg_data[bce_pkg::COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Coefficient count outside the supported range is pulled to its bounds.
    always_comb begin
        if (r_num_coeffs < bce_pkg::NCOEF_W'(bce_pkg::MIN_COEFFS)) begin
            w_ncoef = bce_pkg::NCOEF_W'(bce_pkg::MIN_COEFFS);
        end else if (r_num_coeffs > bce_pkg::NCOEF_W'(bce_pkg::MAX_COEFFS)) begin
            w_ncoef = bce_pkg::NCOEF_W'(bce_pkg::MAX_COEFFS);
        end else begin
            w_ncoef = r_num_coeffs;
        end
    end

    assign w_deg = bce_pkg::IDX_W'(w_ncoef - 1'b1);

    // ------------------------------------------------------------------
    // Normalization: position times reciprocal, then the clip to 1.0.
    // ------------------------------------------------------------------
    bce_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_pos   (i_in.sample_position),
        .i_recip (r_span_recip),
        .o_valid (w_pv[0]),
        .i_ready (w_pr[0]),
        .o_data  (w_pd[0])
    );

    // ------------------------------------------------------------------
    // Power chain: cell k adds t^k and (1-t)^k to what it passes on.
    // ------------------------------------------------------------------
    for (genvar gk = 1; gk < NP; gk++) begin : g_pow
        bce_power_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (bce_pkg::IDX_W'(gk)),
            .i_valid (w_pv[gk-1]),
            .o_ready (w_pr[gk-1]),
            .i_data  (w_pd[gk-1]),
            .o_valid (w_pv[gk]),
            .i_ready (w_pr[gk]),
            .o_data  (w_pd[gk])
        );
    end

    // ------------------------------------------------------------------
    // Basis products and binomial weights for every term.
    // ------------------------------------------------------------------
    bce_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_deg   (w_deg),
        .i_coef  (r_coef),
        .i_valid (w_pv[NP-1]),
        .o_ready (w_pr[NP-1]),
        .i_data  (w_pd[NP-1]),
        .o_valid (w_tv[0]),
        .i_ready (w_tr[0]),
        .o_data  (w_td[0])
    );

    // ------------------------------------------------------------------
    // Accumulation chain: cell i adds the weighted term i.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < NP; gi++) begin : g_term
        bce_term_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (bce_pkg::IDX_W'(gi)),
            .i_valid (w_tv[gi]),
            .o_ready (w_tr[gi]),
            .i_data  (w_td[gi]),
            .o_valid (w_tv[gi+1]),
            .i_ready (w_tr[gi+1]),
            .o_data  (w_td[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Rounding and saturation into the output register. Adding one half
    // and shifting arithmetically rounds halves toward plus infinity.
    // ------------------------------------------------------------------
    assign w_acc_rnd = $signed(w_td[NP].acc + bce_pkg::ACC_W'(bce_pkg::HALF_Q16));
    assign w_res     = w_acc_rnd[bce_pkg::ACC_W-1:bce_pkg::FRAC_W];

    always_comb begin
        if (w_res > RES_MAX) begin
            w_shape = RES_MAX[bce_pkg::SHAPE_W-1:0];
        end else if (w_res < RES_MIN) begin
            w_shape = RES_MIN[bce_pkg::SHAPE_W-1:0];
        end else begin
            w_shape = w_res[bce_pkg::SHAPE_W-1:0];
        end
    end

    assign w_out_rdy = !r_out_valid || o_out.ready;
    assign w_tr[NP]  = w_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_valid <= w_tv[NP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_tv[NP]) begin
            r_shape <= w_shape;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.shape_value = r_shape;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    always_comb begin
        w_chain_busy = 1'b0;
        for (int i = 0; i < NP; i++) begin
            w_chain_busy = w_chain_busy | w_pv[i];
        end
        for (int i = 0; i <= NP; i++) begin
            w_chain_busy = w_chain_busy | w_tv[i];
        end
    end

    // With every cell behind the input empty, a held result must not block input.
    a_ready_when_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_chain_busy |-> i_in.ready)
        else $error("input stalled although the cell chains are empty");

    // A result appears only when the last accumulation cell held an item.
    a_out_from_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_tv[NP]))
        else $error("result appeared without an item in the last cell");

    // A taken result with nothing behind it leaves the output register empty.
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !w_tv[NP]) |=> !o_out.valid)
        else $error("result repeated after its transfer");

    // The working degree always stays within the supported range.
    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deg >= bce_pkg::IDX_W'(bce_pkg::MIN_COEFFS - 1)) &&
        (w_deg <= bce_pkg::IDX_W'(bce_pkg::MAX_COEFFS - 1)))
        else $error("polynomial degree out of range");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for bernstein_curve_eval_core. A directed table
// covers reset values, register extremes and the clamping corners. Random
// phases follow, each with a fresh register setting. Every shape value is
// compared in order against its table value or a local fixed-point model
// of the evaluator, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import bce_pkg::*;

    // The settle window at the end runs PIPE_LATENCY plus a margin.
    localparam int PIPE_LATENCY  = 2 * MAX_COEFFS + 2;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 16;
    // Longest quiet stretch of a correct run: the longest sender gap, the
    // longest receiver stall and the pipeline latency. The limit is taken
    // well above that.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 75;

    localparam longint unsigned Q16_UNIT = 64'd65536;
    localparam longint unsigned Q16_HALF = 64'd32768;

    // One full image of the register file.
    typedef struct packed {
        logic [NCOEF_W-1:0]                   num_coeffs;
        logic [RECIP_W-1:0]                   span_recip;
        logic [NUM_COEF_REGS-1:0][COEF_W-1:0] coef;
    } setting_t;

    // One row of the directed table. When known is set, shape is the value
    // that can be read straight off the register setting. Otherwise the
    // model supplies the expectation.
    typedef struct packed {
        setting_t                  setting;
        logic [POSITION_WIDTH-1:0] position;
        logic                      known;
        logic [SHAPE_W-1:0]        shape;
    } directed_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bce_in_if  in_bus ();
    bce_out_if out_bus ();

    bernstein_curve_eval_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // The register contents that the block currently holds, as the model sees them.
    setting_t           active_setting;
    // Shape values still owed by the block, oldest first.
    logic [SHAPE_W-1:0] shape_q[$];
    directed_row_t      directed_rows[$];
    int                 mismatch_count = 0;
    // When set, the sender offers items back to back.
    bit                 in_gapless;
    logic [SHAPE_W-1:0] owed_shape;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic setting_t make_setting(
        input logic [NCOEF_W-1:0] n, input logic [RECIP_W-1:0] recip,
        input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1,
        input logic [COEF_W-1:0] c2, input logic [COEF_W-1:0] c3,
        input logic [COEF_W-1:0] c4, input logic [COEF_W-1:0] c5);
        setting_t s;
        s.num_coeffs = n;
        s.span_recip = recip;
        s.coef[0]    = c0;
        s.coef[1]    = c1;
        s.coef[2]    = c2;
        s.coef[3]    = c3;
        s.coef[4]    = c4;
        s.coef[5]    = c5;
        return s;
    endfunction

    // Bernstein sum at one position. The arithmetic is exact Q0.16: powers and
    // basis products are rounded half up, and the sum is held in Q4.28.
    // It is rounded to Q4.12 with halves going up, then clipped.
    function automatic logic [SHAPE_W-1:0] predict_shape(
        input setting_t s, input logic [POSITION_WIDTH-1:0] pos);
        int                n;
        int                d;
        int                i;
        int                j;
        longint unsigned   t;
        longint unsigned   u;
        longint unsigned   ways;
        longint unsigned   prod;
        longint unsigned   t_pow[MAX_COEFFS];
        longint unsigned   u_pow[MAX_COEFFS];
        longint            term;
        longint            acc;
        n = int'(s.num_coeffs);
        // Counts outside the legal range collapse onto the nearest legal one.
        if (n < MIN_COEFFS) begin
            n = MIN_COEFFS;
        end
        if (n > MAX_COEFFS) begin
            n = MAX_COEFFS;
        end
        d = n - 1;
        t = (longint'(pos) * longint'(s.span_recip)) >> 16;
        if (t > Q16_UNIT) begin
            t = Q16_UNIT;
        end
        u = Q16_UNIT - t;
        t_pow[0] = Q16_UNIT;
        u_pow[0] = Q16_UNIT;
        for (i = 1; i < n; i++) begin
            t_pow[i] = (t_pow[i-1] * t + Q16_HALF) >> 16;
            u_pow[i] = (u_pow[i-1] * u + Q16_HALF) >> 16;
        end
        acc = 0;
        for (i = 0; i < n; i++) begin
            ways = 1;
            for (j = 0; j < i; j++) begin
                ways = ways * longint'(d - j) / longint'(j + 1);
            end
            prod = (t_pow[i] * u_pow[d-i] + Q16_HALF) >> 16;
            term = longint'(ways * prod);
            acc  = acc + longint'($signed(s.coef[i])) * term;
        end
        // An arithmetic shift floors, which gives round-half-up after the bias.
        acc = (acc + longint'(Q16_HALF)) >>> 16;
        if (acc > 32767) begin
            acc = 32767;
        end else if (acc < -32768) begin
            acc = -32768;
        end
        return acc[SHAPE_W-1:0];
    endfunction

    task automatic add_row(input setting_t s, input logic [POSITION_WIDTH-1:0] pos,
                           input logic known, input logic [SHAPE_W-1:0] shape);
        directed_row_t row;
        row.setting  = s;
        row.position = pos;
        row.known    = known;
        row.shape    = shape;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge. It drives one register write and returns at
    // the next falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every owed result has arrived. Since each
    // position yields exactly one result, an empty queue means the pipeline is
    // empty as well.
    task automatic wait_drained();
        in_bus.valid = 1'b0;
        while (shape_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Writes every register while the block is idle. Unused high bits of the
    // write data carry noise, which the block has to ignore.
    task automatic load_setting(input setting_t s);
        int                    k;
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_NUM_COEFFS, {junk[CFG_DATA_W-1:NCOEF_W], s.num_coeffs});
        write_reg(CFG_SPAN_RECIP, s.span_recip);
        for (k = 0; k < NUM_COEF_REGS; k++) begin
            junk = CFG_DATA_W'($urandom);
            write_reg(CFG_COEF_ZERO + CFG_IDX_W'(k),
                      {junk[CFG_DATA_W-1:COEF_W], s.coef[k]});
        end
        i_cfg_we       = 1'b0;
        active_setting = s;
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99);
        if (in_gapless || pick < 70) begin
            return 0;
        end else if (pick < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Called at a falling edge. It offers one position and holds it until the
    // transfer completes. The owed shape value is queued at that transfer edge.
    // valid is left high, so an item that follows at once costs no bubble.
    // Any caller that pauses lowers valid at the same falling edge.
    task automatic send_position(input logic [POSITION_WIDTH-1:0] pos, input logic known,
                                 input logic [SHAPE_W-1:0] shape, input int gap);
        if (gap > 0) begin
            in_bus.valid           = 1'b0;
            in_bus.sample_position = POSITION_WIDTH'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid           = 1'b1;
        in_bus.sample_position = pos;
        do begin
            @(posedge i_clk);
        end while (in_bus.ready !== 1'b1);
        if (known) begin
            shape_q.push_back(shape);
        end else begin
            shape_q.push_back(predict_shape(active_setting, pos));
        end
        @(negedge i_clk);
    endtask

    // Receiver: alternating runs of ready and stall. Most stalls are too short to
    // fill the pipeline, and now and then one is long enough to back it up to
    // the input. Now and then a ready run is much longer than the rest.
    initial begin
        int hold;
        int pick;
        hold          = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                pick = $urandom_range(99);
                if (out_bus.ready) begin
                    out_bus.ready = 1'b0;
                    hold = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(20, 60);
                end else begin
                    out_bus.ready = 1'b1;
                    hold = (pick < 15) ? $urandom_range(100, 300) : $urandom_range(1, 20);
                end
            end else begin
                hold--;
            end
        end
    end

    // Checker: every output transfer is matched against the oldest owed value.
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (shape_q.size() == 0) begin
                report_mismatch($sformatf("shape_value %0d with no result owed",
                                          $signed(out_bus.shape_value)));
            end else begin
                owed_shape = shape_q.pop_front();
                if (out_bus.shape_value !== owed_shape) begin
                    report_mismatch($sformatf("shape_value got %0d expected %0d",
                                              $signed(out_bus.shape_value),
                                              $signed(owed_shape)));
                end
            end
        end
    end

    // Watchdog: ends the run once too many cycles in a row pass without any
    // transfer, register write or reset.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (in_bus.valid && in_bus.ready)
                    || (out_bus.valid && out_bus.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
        $display("bernstein_curve_eval_core regression: fail");
        $finish;
    end

    // Main sequence.
    initial begin
        int                        p;
        int                        k;
        int                        pick;
        setting_t                  s;
        setting_t                  s_reset;
        setting_t                  s_line;
        setting_t                  s_line_steep;
        setting_t                  s_zero_recip;
        setting_t                  s_count_zero;
        setting_t                  s_count_one;
        setting_t                  s_count_seven;
        setting_t                  s_all_max;
        setting_t                  s_all_min;
        setting_t                  s_zigzag;
        setting_t                  s_cubic;
        setting_t                  s_quartic;
        logic [POSITION_WIDTH-1:0] pos;

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_data             = '0;
        in_bus.valid           = 1'b0;
        in_bus.sample_position = '0;
        in_gapless             = 1'b0;

        s_reset        = make_setting(NUM_COEFFS_RST, SPAN_RECIP_RST,
                                      '0, '0, '0, '0, '0, '0);
        active_setting = s_reset;

        // Linear case. Coefficients past the count hold large values that
        // must not leak into the sum.
        s_line        = make_setting(3'd2, 24'd65536, 16'h1000, 16'h2000,
                                     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        // The largest reciprocal drives t to 1.0 for nearly every position.
        s_line_steep  = make_setting(3'd2, 24'hFFFFFF, 16'h1000, 16'h2000,
                                     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        // A zero reciprocal pins t to 0, so only coef_zero counts.
        s_zero_recip  = make_setting(3'd6, 24'd0, 16'hEDCC, 16'h1111,
                                     16'h2222, 16'h3333, 16'h4444, 16'h5555);
        // Counts of zero and one behave as two, and a count of seven as six.
        s_count_zero  = make_setting(3'd0, 24'hFFFFFF, 16'h0111, 16'h0222,
                                     16'h0333, 16'h0444, 16'h0555, 16'h0666);
        s_count_one   = make_setting(3'd1, 24'hFFFFFF, 16'h0111, 16'h0222,
                                     16'h0333, 16'h0444, 16'h0555, 16'h0666);
        s_count_seven = make_setting(3'd7, 24'hFFFFFF, 16'h0111, 16'h0222,
                                     16'h0333, 16'h0444, 16'h0555, 16'h0666);
        // Extreme weights. Rounding of the basis can push the sum past the
        // Q4.12 range, where the output has to saturate.
        s_all_max     = make_setting(3'd6, 24'd65536, 16'h7FFF, 16'h7FFF,
                                     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        s_all_min     = make_setting(3'd6, 24'd65536, 16'h8000, 16'h8000,
                                     16'h8000, 16'h8000, 16'h8000, 16'h8000);
        s_zigzag      = make_setting(3'd3, 24'd131072, 16'h8000, 16'h7FFF,
                                     16'h8000, 16'h1234, 16'h1234, 16'h1234);
        s_cubic       = make_setting(3'd4, 24'h012345, 16'h0800, 16'hF000,
                                     16'h3000, 16'hC400, 16'h7FFF, 16'h7FFF);
        s_quartic     = make_setting(3'd5, 24'h00C000, 16'hFC00, 16'h2400,
                                     16'h8000, 16'h7FFF, 16'h0100, 16'h8000);

        // Right after reset, all weights are zero.
        add_row(s_reset,       16'd0,     1'b1, 16'd0);
        add_row(s_reset,       16'hFFFF,  1'b1, 16'd0);
        add_row(s_line,        16'd0,     1'b1, 16'h1000);
        add_row(s_line,        16'd32768, 1'b0, '0);
        add_row(s_line,        16'hFFFF,  1'b0, '0);
        add_row(s_line_steep,  16'hFFFF,  1'b1, 16'h2000);
        add_row(s_line_steep,  16'd1,     1'b0, '0);
        add_row(s_zero_recip,  16'hFFFF,  1'b1, 16'hEDCC);
        add_row(s_count_zero,  16'hFFFF,  1'b1, 16'h0222);
        add_row(s_count_zero,  16'd100,   1'b0, '0);
        add_row(s_count_one,   16'hFFFF,  1'b1, 16'h0222);
        add_row(s_count_seven, 16'hFFFF,  1'b1, 16'h0666);
        add_row(s_count_seven, 16'd0,     1'b1, 16'h0111);
        add_row(s_all_max,     16'd0,     1'b1, 16'h7FFF);
        add_row(s_all_max,     16'd32768, 1'b0, '0);
        add_row(s_all_max,     16'd21845, 1'b0, '0);
        add_row(s_all_min,     16'd0,     1'b1, 16'h8000);
        add_row(s_all_min,     16'd40000, 1'b0, '0);
        add_row(s_zigzag,      16'd16384, 1'b0, '0);
        add_row(s_zigzag,      16'hFFFF,  1'b1, 16'h8000);
        add_row(s_cubic,       16'd12345, 1'b0, '0);
        add_row(s_cubic,       16'd54321, 1'b0, '0);
        add_row(s_quartic,     16'd30000, 1'b0, '0);
        add_row(s_quartic,     16'hAAAA,  1'b0, '0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table. The registers are reloaded only when a row's
        // setting differs from the current one. The first rows therefore see
        // the reset values.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].setting != active_setting) begin
                load_setting(directed_rows[k].setting);
            end
            send_position(directed_rows[k].position, directed_rows[k].known,
                          directed_rows[k].shape, pick_gap());
        end

        // Random phases. Each one draws a setting and then streams positions.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                s.num_coeffs = NCOEF_W'($urandom_range(MIN_COEFFS, MAX_COEFFS));
            end else begin
                pick         = $urandom_range(0, 2);
                s.num_coeffs = (pick == 2) ? NCOEF_W'(7) : NCOEF_W'(pick);
            end
            // Reciprocals are mostly near 1.0, so that t sweeps its whole range.
            pick = $urandom_range(99);
            if (pick < 60) begin
                s.span_recip = RECIP_W'($urandom_range(32768, 262144));
            end else if (pick < 70) begin
                s.span_recip = RECIP_W'(65536);
            end else if (pick < 80) begin
                s.span_recip = RECIP_W'($urandom);
            end else if (pick < 90) begin
                s.span_recip = RECIP_W'($urandom_range(0, 4096));
            end else begin
                s.span_recip = $urandom_range(0, 1) ? {RECIP_W{1'b1}} : '0;
            end
            for (k = 0; k < NUM_COEF_REGS; k++) begin
                pick = $urandom_range(99);
                if (pick < 80 && p != 2) begin
                    s.coef[k] = COEF_W'($urandom);
                end else begin
                    case ($urandom_range(0, 2))
                        0: s.coef[k] = 16'h7FFF;
                        1: s.coef[k] = 16'h8000;
                        default: s.coef[k] = 16'h0000;
                    endcase
                end
            end
            // The first phases pin the register extremes: the smallest count with a
            // zero reciprocal, the top raw count with the largest reciprocal, then the
            // largest legal count at reciprocal 1.0, weights drawn from 7FFF, 8000 and 0.
            if (p == 0) begin
                s.num_coeffs = NCOEF_W'(MIN_COEFFS);
                s.span_recip = '0;
            end else if (p == 1) begin
                s.num_coeffs = NCOEF_W'(7);
                s.span_recip = {RECIP_W{1'b1}};
            end else if (p == 2) begin
                s.num_coeffs = NCOEF_W'(MAX_COEFFS);
                s.span_recip = RECIP_W'(65536);
            end
            load_setting(s);
            in_gapless = (p % 4 == 3);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                // In some phases the sender stops halfway and lets the
                // pipeline drain fully before it resumes.
                if (k == PHASE_ITEMS / 2 && p % 3 == 0) begin
                    wait_drained();
                end
                pick = $urandom_range(99);
                if (pick < 85) begin
                    pos = POSITION_WIDTH'($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0: pos = '0;
                        1: pos = '1;
                        2: pos = POSITION_WIDTH'(1);
                        default: pos = POSITION_WIDTH'(32768);
                    endcase
                end
                send_position(pos, 1'b0, '0, pick_gap());
            end
        end

        // Let everything owed arrive. Then watch a little longer for stray
        // results.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (shape_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", shape_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("bernstein_curve_eval_core regression: pass");
        end else begin
            $display("bernstein_curve_eval_core regression: fail");
        end
        $finish;
    end

endmodule
